// ===== hw/rtl/pad_edge_to_midi_notes_assert.svh =====
// Assertion macros shared by the pad edge to MIDI note block.
// Used by the top level only; no other dependencies.
`ifndef PAD_EDGE_TO_MIDI_NOTES_ASSERT_SVH
`define PAD_EDGE_TO_MIDI_NOTES_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define PEMN_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PEMN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds at every rising edge outside reset.
`define PEMN_ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`else

`define PEMN_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define PEMN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`define PEMN_ASSERT_ALWAYS(name, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/pemn_pkg.sv =====
// Package for the pad edge to MIDI note block: widths, codes, types, scale tables.
// No dependencies; used by every module of the block.
package pemn_pkg;

    localparam int PAD_W        = 8;
    localparam int IDX_W        = 3;
    localparam int NOTE_W       = 7;
    localparam int CHAN_W       = 4;
    localparam int TONE_W       = 4;
    localparam int OCT_W        = 3;
    localparam int CFG_DATA_W   = 56;
    localparam int CFG_IDX_W    = 3;
    localparam int OFS_W        = 4;
    localparam int NUM_PADS_DEF = 8;

    // Scan queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [NOTE_W-1:0] SCALE_VELOCITY = 7'd120;
    localparam logic [OCT_W-1:0]  OCTAVE_RESET   = 3'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_MODE       = 3'd0,
        CFG_TONALITY        = 3'd1,
        CFG_OCTAVE          = 3'd2,
        CFG_CHANNEL         = 3'd3,
        CFG_DRUM_NOTES      = 3'd4,
        CFG_DRUM_VELOCITIES = 3'd5
    } cfg_index_t;

    // Tonality codes.
    localparam logic [TONE_W-1:0] TONE_CHROMATIC = 4'd0;
    localparam logic [TONE_W-1:0] TONE_C_MAJOR   = 4'd1;
    localparam logic [TONE_W-1:0] TONE_G_MAJOR   = 4'd2;
    localparam logic [TONE_W-1:0] TONE_D_MAJOR   = 4'd3;
    localparam logic [TONE_W-1:0] TONE_A_MAJOR   = 4'd4;
    localparam logic [TONE_W-1:0] TONE_A_MINOR   = 4'd5;
    localparam logic [TONE_W-1:0] TONE_D_MINOR   = 4'd6;
    localparam logic [TONE_W-1:0] TONE_G_MINOR   = 4'd7;
    localparam logic [TONE_W-1:0] TONE_C_MINOR   = 4'd8;
    localparam logic [TONE_W-1:0] TONE_G_BLUES   = 4'd9;
    localparam logic [TONE_W-1:0] TONE_E_BLUES   = 4'd10;

    // Scale families that share one interval pattern.
    typedef enum logic [1:0] {
        SCALE_CHROMATIC,
        SCALE_MAJOR,
        SCALE_MINOR,
        SCALE_BLUES
    } scale_t;

    // Cumulative offsets from the base note, one entry per pad.
    localparam logic [OFS_W-1:0] MAJOR_OFS [PAD_W] = '{4'd0, 4'd2, 4'd4, 4'd5,
                                                      4'd7, 4'd9, 4'd11, 4'd12};
    localparam logic [OFS_W-1:0] MINOR_OFS [PAD_W] = '{4'd0, 4'd2, 4'd3, 4'd5,
                                                      4'd7, 4'd8, 4'd10, 4'd12};
    localparam logic [OFS_W-1:0] BLUES_OFS [PAD_W] = '{4'd0, 4'd3, 4'd5, 4'd6,
                                                      4'd7, 4'd10, 4'd12, 4'd15};

    typedef struct packed {
        logic                  play_mode;
        logic [TONE_W-1:0]     tonality;
        logic [OCT_W-1:0]      octave;
        logic [CHAN_W-1:0]     channel;
        logic [CFG_DATA_W-1:0] drum_notes;
        logic [CFG_DATA_W-1:0] drum_velocities;
    } cfg_t;

    // One scan that changed at least one pad.
    typedef struct packed {
        logic [PAD_W-1:0] changes;
        logic [PAD_W-1:0] levels;
    } scan_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic              is_note_on;
        logic [IDX_W-1:0]  pad_index;
        logic [NOTE_W-1:0] note_number;
        logic [NOTE_W-1:0] velocity;
        logic [CHAN_W-1:0] midi_channel;
        logic              last_event;
    } event_t;

    // Family of a tonality code; codes past the list play chromatic.
    function automatic scale_t scale_of(input logic [TONE_W-1:0] t);
        scale_t s;
        s = SCALE_CHROMATIC;
        if (t >= TONE_C_MAJOR && t <= TONE_A_MAJOR)
            s = SCALE_MAJOR;
        else if (t >= TONE_A_MINOR && t <= TONE_C_MINOR)
            s = SCALE_MINOR;
        else if (t == TONE_G_BLUES || t == TONE_E_BLUES)
            s = SCALE_BLUES;
        return s;
    endfunction

    // Base note of a tonality at octave one.
    function automatic logic [NOTE_W-1:0] tone_base(input logic [TONE_W-1:0] t);
        logic [NOTE_W-1:0] b;
        unique case (t)
            TONE_G_MAJOR, TONE_G_MINOR, TONE_G_BLUES: b = 7'd31;
            TONE_D_MAJOR, TONE_D_MINOR:               b = 7'd26;
            TONE_A_MAJOR, TONE_A_MINOR:               b = 7'd33;
            TONE_E_BLUES:                             b = 7'd28;
            default:                                  b = 7'd24;
        endcase
        return b;
    endfunction

    // Offset of a pad from the base note.
    function automatic logic [OFS_W-1:0] scale_offset(input scale_t s,
                                                      input logic [IDX_W-1:0] pad);
        logic [OFS_W-1:0] o;
        unique case (s)
            SCALE_MAJOR: o = MAJOR_OFS[pad];
            SCALE_MINOR: o = MINOR_OFS[pad];
            SCALE_BLUES: o = BLUES_OFS[pad];
            default:     o = OFS_W'(pad);
        endcase
        return o;
    endfunction

endpackage

// ===== hw/rtl/pemn_front.sv =====
// Front end: accepts pad scans, primes on the first one, finds changed pads.
// Depends on pemn_pkg; pushes scans with changes into pemn_queue.
module pemn_front #(
    parameter int NUM_PADS = pemn_pkg::NUM_PADS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [pemn_pkg::PAD_W-1:0]  pad_levels,
    input  pemn_pkg::q_status_t         q_status,
    output logic                        q_push,
    output pemn_pkg::scan_t             q_wdata
);

    localparam logic [pemn_pkg::PAD_W-1:0] PAD_MASK =
        (NUM_PADS >= pemn_pkg::PAD_W) ? {pemn_pkg::PAD_W{1'b1}}
                                      : pemn_pkg::PAD_W'((1 << NUM_PADS) - 1);

    logic [pemn_pkg::PAD_W-1:0] prev_reg;
    logic [pemn_pkg::PAD_W-1:0] prev_next;
    logic                       primed_reg;
    logic                       primed_next;
    logic [pemn_pkg::PAD_W-1:0] levels;
    logic                       accept;

    // Classify the incoming word against the stored levels.
    always_comb
    begin
        accept          = push && !q_status.full;
        levels          = pad_levels & PAD_MASK;
        prev_next       = accept ? levels : prev_reg;
        primed_next     = primed_reg || accept;
        q_wdata.levels  = levels;
        q_wdata.changes = levels ^ prev_reg;
        q_push          = accept && primed_reg && (q_wdata.changes != '0);
    end

    // Stored levels and the primed flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            primed_reg <= primed_next;
        end
    end

endmodule

// ===== hw/rtl/pemn_queue.sv =====
// Short queue of changed scans between the front and the back end.
// Depends on pemn_pkg for the scan type and the depth constants.
module pemn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  pemn_pkg::scan_t     wdata,
    input  logic                rd_en,
    output pemn_pkg::scan_t     rdata,
    output pemn_pkg::q_status_t status
);

    pemn_pkg::scan_t                   mem_reg [pemn_pkg::Q_DEPTH];
    logic [pemn_pkg::Q_AW-1:0]         wr_ptr_reg;
    logic [pemn_pkg::Q_AW-1:0]         wr_ptr_next;
    logic [pemn_pkg::Q_AW-1:0]         rd_ptr_reg;
    logic [pemn_pkg::Q_AW-1:0]         rd_ptr_next;
    logic [pemn_pkg::Q_CNT_W-1:0]      count_reg;
    logic [pemn_pkg::Q_CNT_W-1:0]      count_next;
    logic                              do_wr;
    logic                              do_rd;

    // Pointer and fill count update.
    always_comb
    begin
        status.count = count_reg;
        status.full  = (count_reg == pemn_pkg::Q_CNT_W'(pemn_pkg::Q_DEPTH));
        status.empty = (count_reg == '0);
        do_wr        = wr_en && !status.full;
        do_rd        = rd_en && !status.empty;
        wr_ptr_next  = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
        rdata        = mem_reg[rd_ptr_reg];
    end

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/pemn_back.sv =====
// Back end: walks a scan's changed pads, lowest first, one note event a cycle unless stalled.
// Depends on pemn_pkg; reads scans from pemn_queue and current configuration.
module pemn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pemn_pkg::cfg_t      cfg,
    input  pemn_pkg::scan_t     q_rdata,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic                ev_take,
    output logic                ev_valid,
    output pemn_pkg::event_t    ev
);

    logic [pemn_pkg::PAD_W-1:0]  pend_reg;
    logic [pemn_pkg::PAD_W-1:0]  pend_next;
    logic [pemn_pkg::PAD_W-1:0]  lev_reg;
    logic [pemn_pkg::PAD_W-1:0]  lev_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    pemn_pkg::event_t            ev_reg;
    pemn_pkg::event_t            ev_next;

    logic                        busy;
    logic                        src_valid;
    logic [pemn_pkg::PAD_W-1:0]  src_changes;
    logic [pemn_pkg::PAD_W-1:0]  src_levels;
    logic [pemn_pkg::PAD_W-1:0]  remaining;
    logic [pemn_pkg::IDX_W-1:0]  idx;
    logic                        advance;
    logic [pemn_pkg::NOTE_W-1:0] drum_note [pemn_pkg::PAD_W];
    logic [pemn_pkg::NOTE_W-1:0] drum_vel  [pemn_pkg::PAD_W];
    pemn_pkg::scale_t            scale;
    logic [pemn_pkg::PAD_W-1:0]  base;
    logic [pemn_pkg::PAD_W-1:0]  scale_note;
    logic [pemn_pkg::NOTE_W-1:0] note;
    logic [pemn_pkg::NOTE_W-1:0] vel;

    // Pick the next changed pad, from the held scan or the queue head.
    always_comb
    begin
        busy        = (pend_reg != '0);
        src_valid   = busy || !q_empty;
        src_changes = busy ? pend_reg : q_rdata.changes;
        src_levels  = busy ? lev_reg : q_rdata.levels;
        idx         = '0;
        for (int i = pemn_pkg::PAD_W - 1; i >= 0; i--)
        begin
            if (src_changes[i])
                idx = pemn_pkg::IDX_W'(i);
        end
        remaining = src_changes & (src_changes - 1'b1);
        advance   = src_valid && (!out_valid_reg || ev_take);
        q_pop     = advance && !busy;
    end

    // Note and velocity of the selected pad from the current registers.
    always_comb
    begin
        for (int p = 0; p < pemn_pkg::PAD_W; p++)
        begin
            drum_note[p] = cfg.drum_notes[p*pemn_pkg::NOTE_W +: pemn_pkg::NOTE_W];
            drum_vel[p]  = cfg.drum_velocities[p*pemn_pkg::NOTE_W +: pemn_pkg::NOTE_W];
        end
        scale = pemn_pkg::scale_of(cfg.tonality);
        // Base plus twelve per octave above one; every tone base is at least 24.
        base = pemn_pkg::PAD_W'(pemn_pkg::tone_base(cfg.tonality))
             + pemn_pkg::PAD_W'({cfg.octave, 3'b000})
             + pemn_pkg::PAD_W'({cfg.octave, 2'b00})
             - pemn_pkg::PAD_W'(12);
        scale_note = base + pemn_pkg::PAD_W'(pemn_pkg::scale_offset(scale, idx));
        if (cfg.play_mode)
        begin
            note = drum_note[idx];
            vel  = drum_vel[idx];
        end
        else
        begin
            note = scale_note[pemn_pkg::NOTE_W-1:0];
            vel  = pemn_pkg::SCALE_VELOCITY;
        end
    end

    // Next output word and walker state.
    always_comb
    begin
        pend_next      = pend_reg;
        lev_next       = lev_reg;
        ev_next        = ev_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            pend_next            = remaining;
            lev_next             = src_levels;
            out_valid_next       = 1'b1;
            ev_next.is_note_on   = src_levels[idx];
            ev_next.pad_index    = idx;
            ev_next.note_number  = note;
            ev_next.velocity     = src_levels[idx] ? vel : '0;
            ev_next.midi_channel = cfg.channel;
            ev_next.last_event   = (remaining == '0);
        end
        else if (ev_take)
        begin
            out_valid_next = 1'b0;
        end
        ev_valid = out_valid_reg;
        ev       = ev_reg;
    end

    // Output word payload needs no reset.
    always_ff @(posedge clk)
    begin
        ev_reg  <= ev_next;
        lev_reg <= lev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/pad_edge_to_midi_notes.sv =====
// Top level of the pad edge to MIDI note block: configuration registers and wiring.
// Depends on pemn_pkg, pemn_front, pemn_queue, pemn_back and the assertion header.
//
//  Channel   Signals                                      Direction
//  -------   -------------------------------------------  ---------
//  scans     push, full, pad_levels                       in
//  events    empty, pop, is_note_on, pad_index,           out
//            note_number, velocity, midi_channel,
//            last_event
//  config    cfg_we, cfg_index, cfg_data                  in
//
// A scan is taken while the queue is not full; each changed pad then becomes one event,
// so a scan with changes yields one to eight events, held by the single-event output register.
// The first event of a scan passes through the scan queue and then the output register.
// A two-entry scan queue lets scans arrive while events wait on pop.
// Reset clears the stored levels and the primed flag; the first scan only primes.
`include "pad_edge_to_midi_notes_assert.svh"

module pad_edge_to_midi_notes #(
    parameter int NUM_PADS = pemn_pkg::NUM_PADS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Scan input
    input  logic                             push,
    output logic                             full,
    input  logic [pemn_pkg::PAD_W-1:0]       pad_levels,
    // Event output
    output logic                             empty,
    input  logic                             pop,
    output logic                             is_note_on,
    output logic [pemn_pkg::IDX_W-1:0]       pad_index,
    output logic [pemn_pkg::NOTE_W-1:0]      note_number,
    output logic [pemn_pkg::NOTE_W-1:0]      velocity,
    output logic [pemn_pkg::CHAN_W-1:0]      midi_channel,
    output logic                             last_event,
    // Configuration
    input  logic                             cfg_we,
    input  logic [pemn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pemn_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pemn_pkg::cfg_t      cfg_reg;
    pemn_pkg::cfg_t      cfg_next;
    pemn_pkg::q_status_t q_status;
    pemn_pkg::scan_t     q_wdata;
    pemn_pkg::scan_t     q_rdata;
    pemn_pkg::event_t    ev;
    logic                q_push;
    logic                q_pop;
    logic                ev_valid;
    logic                ev_take;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pemn_pkg::CFG_PLAY_MODE:
                    cfg_next.play_mode = cfg_data[0];
                pemn_pkg::CFG_TONALITY:
                    cfg_next.tonality = cfg_data[pemn_pkg::TONE_W-1:0];
                pemn_pkg::CFG_OCTAVE:
                    cfg_next.octave = cfg_data[pemn_pkg::OCT_W-1:0];
                pemn_pkg::CFG_CHANNEL:
                    cfg_next.channel = cfg_data[pemn_pkg::CHAN_W-1:0];
                pemn_pkg::CFG_DRUM_NOTES:
                    cfg_next.drum_notes = cfg_data;
                pemn_pkg::CFG_DRUM_VELOCITIES:
                    cfg_next.drum_velocities = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_mode       <= 1'b0;
            cfg_reg.tonality        <= pemn_pkg::TONE_CHROMATIC;
            cfg_reg.octave          <= pemn_pkg::OCTAVE_RESET;
            cfg_reg.channel         <= '0;
            cfg_reg.drum_notes      <= '0;
            cfg_reg.drum_velocities <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: edge detection and priming.
    pemn_front #(
        .NUM_PADS (NUM_PADS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pad_levels (pad_levels),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Queue of scans with changes.
    pemn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wdata  (q_wdata),
        .rd_en  (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // Back end: one note event per changed pad.
    pemn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_rdata  (q_rdata),
        .q_empty  (q_status.empty),
        .q_pop    (q_pop),
        .ev_take  (ev_take),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // Port drive.
    assign full         = q_status.full;
    assign empty        = !ev_valid;
    assign ev_take      = pop && ev_valid;
    assign is_note_on   = ev.is_note_on;
    assign pad_index    = ev.pad_index;
    assign note_number  = ev.note_number;
    assign velocity     = ev.velocity;
    assign midi_channel = ev.midi_channel;
    assign last_event   = ev.last_event;

    // Checks on the queue fill and the event sequence of one scan.
    `PEMN_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, (q_status.count <= pemn_pkg::Q_CNT_W'(pemn_pkg::Q_DEPTH)), "scan queue over its depth")
    `PEMN_ASSERT_IMPL(a_off_zero_vel, clk, rst_n, (!empty && !is_note_on), (velocity == '0), "note-off with nonzero velocity")
    `PEMN_ASSERT_NEXT(a_pad_order, clk, rst_n, (pop && !empty && !last_event), (!empty && (pad_index > $past(pad_index))), "events of a scan out of pad order")

endmodule
